### design/appm_pkg.sv
// Package for the ASCII ppm line parser.
// Holds line geometry, character codes and the result type; depends on nothing.
package appm_pkg;

    localparam int BUF_LEN    = 20;
    localparam int POS_W      = $clog2(BUF_LEN);
    localparam int LINE_KEEP  = 9;
    localparam int LINE_TOTAL = 10;
    localparam int VALUE_W    = 14;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_P     = 8'h70;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [VALUE_W-1:0] WEIGHT_THOUSANDS = 14'd1000;
    localparam logic [VALUE_W-1:0] WEIGHT_HUNDREDS  = 14'd100;
    localparam logic [VALUE_W-1:0] WEIGHT_TENS      = 14'd10;

    typedef struct packed {
        logic               parse_error;
        logic [VALUE_W-1:0] ppm_value;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

### design/ascii_ppm_line_parser.sv
// Top level of the ASCII ppm line parser.
// Depends on appm_pkg and instantiates appm_line_decode.
//
// The input channel (in_valid, in_stall, rx_byte) carries one received
// serial byte per word. The output channel (out_valid, out_stall,
// ppm_value, parse_error) carries one word for each newline that lands
// at the tenth position of a line; every other byte gives no word.
// A word is accepted at a clock edge where valid is high and stall low.
// Each byte is taken into an input register, then framed and, on a line
// end, decoded in a single pass into the output register once that
// register is free. One byte is accepted every cycle while the output
// side keeps up.
// When the receiver stalls with a result pending, the byte in the input
// register waits and in_stall rises until the result is taken.
// Reset clears the line position and both valid flags; stored line bytes
// are never read before being written and need no clearing.
module ascii_ppm_line_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [appm_pkg::VALUE_W-1:0] ppm_value,
    output logic                         parse_error
);
    import appm_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       byte_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       line_bytes_reg  [LINE_KEEP];
    logic [7:0]       line_bytes_next [LINE_KEEP];
    logic             out_valid_reg, out_valid_next;
    result_t          result_reg, result_next;
    result_t          decoded;
    logic             out_free;
    logic             step;
    logic             emit;

    appm_line_decode u_decode (
        .line_bytes (line_bytes_reg),
        .result     (decoded)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_comb
    begin
        in_valid_next   = in_stall ? in_valid_reg : in_valid;
        pos_next        = pos_reg;
        line_bytes_next = line_bytes_reg;
        emit            = 1'b0;
        if (step)
        begin
            if (pos_reg == POS_W'(BUF_LEN - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                for (int i = 0; i < LINE_KEEP; i++)
                begin
                    if (pos_reg == POS_W'(i))
                    begin
                        line_bytes_next[i] = byte_reg;
                    end
                end
                if (byte_reg == CHAR_LF)
                begin
                    pos_next = '0;
                    emit     = (pos_reg == POS_W'(LINE_TOTAL - 1));
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
        out_valid_next = out_free ? emit : out_valid_reg;
        result_next    = (out_free && emit) ? decoded : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= rx_byte;
        end
        line_bytes_reg <= line_bytes_next;
        result_reg     <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign ppm_value   = result_reg.ppm_value;
    assign parse_error = result_reg.parse_error;

endmodule

### design/appm_line_decode.sv
// Format check and decimal decode of one stored line.
// Depends on appm_pkg for character codes, weights and the result type.
module appm_line_decode (
    input  logic [7:0]       line_bytes [appm_pkg::LINE_KEEP],
    output appm_pkg::result_t result
);
    import appm_pkg::*;

    logic       suffix_ok;
    logic [3:0] dig_ok;
    logic [3:0] spc_ok;
    logic [3:0] d0, d1, d2, d3;
    logic       nz0, nz1;
    logic       line_ok;
    logic [VALUE_W-1:0] value;

    always_comb
    begin
        suffix_ok = (line_bytes[4] == CHAR_SPACE) && (line_bytes[5] == CHAR_P) &&
                    (line_bytes[6] == CHAR_P) && (line_bytes[7] == CHAR_M) &&
                    (line_bytes[8] == CHAR_CR);
        for (int k = 0; k < 4; k++)
        begin
            dig_ok[k] = is_digit(line_bytes[k]);
            spc_ok[k] = (line_bytes[k] == CHAR_SPACE);
        end
        d0 = dig_ok[0] ? line_bytes[0][3:0] : 4'd0;
        d1 = dig_ok[1] ? line_bytes[1][3:0] : 4'd0;
        d2 = dig_ok[2] ? line_bytes[2][3:0] : 4'd0;
        d3 = line_bytes[3][3:0];
        nz0 = (d0 != 4'd0);
        nz1 = (d1 != 4'd0);
        line_ok = suffix_ok && dig_ok[3] &&
                  (dig_ok[0] || spc_ok[0]) &&
                  (dig_ok[1] || (spc_ok[1] && !nz0)) &&
                  (dig_ok[2] || (spc_ok[2] && !nz0 && !nz1));
        value = VALUE_W'(d0) * WEIGHT_THOUSANDS + VALUE_W'(d1) * WEIGHT_HUNDREDS +
                VALUE_W'(d2) * WEIGHT_TENS + VALUE_W'(d3);
        result.parse_error = !line_ok;
        result.ppm_value   = line_ok ? value : '0;
    end

endmodule

### design/appm_checker.sv
// Port-level checks for the ASCII ppm line parser, bound to its top level.
// Depends on appm_pkg for the value width.
module appm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [appm_pkg::VALUE_W-1:0] ppm_value,
    input logic                         parse_error
);
    import appm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(ppm_value) && $stable(parse_error))
        else $error("stalled result word changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_error |-> ppm_value == '0)
        else $error("malformed line gave a nonzero value");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ppm_value <= VALUE_W'(9999))
        else $error("decoded value out of range");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result word without a byte accepted two cycles before");

endmodule

bind ascii_ppm_line_parser appm_checker u_appm_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for ascii_ppm_line_parser: drives framed sensor lines and noise
// bytes with random idling on both channels and checks every result word against a line
// predictor in step with accepted bytes or a listed result. Depends on appm_pkg, the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import appm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TARGET_BYTES = 1550;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIR_ROWS     = 5;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [VALUE_W-1:0] ppm_value;
    logic               parse_error;

    int unsigned line_pos;
    logic [7:0]  line_mem [LINE_KEEP];
    result_t     expected_ppm_q [$];
    result_t     typed_res;
    bit          use_typed;
    bit          no_idle;
    int          bytes_sent;
    int          err_count = 0;
    int          cycles = 0;

    string              dir_text  [DIR_ROWS] = '{"9999 ppm\015\012", "   0 ppm\015\012",
                                                "0 12 ppm\015\012", "\377\012",
                                                "1 23 ppm\015\012"};
    bit                 dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    logic [VALUE_W-1:0] dir_ppm   [DIR_ROWS] = '{14'd9999, 14'd0, 14'd0, 14'd0, 14'd0};
    logic               dir_err   [DIR_ROWS] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

    ascii_ppm_line_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ppm_value   (ppm_value),
        .parse_error (parse_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_non_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_LF)
            b = CHAR_SPACE;
        return b;
    endfunction

    function automatic logic [7:0] value_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return CHAR_ZERO + 8'($urandom_range(0, 9));
        else if (r < 95)
            return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit decode_value(output logic [VALUE_W-1:0] v);
        int         acc;
        logic [7:0] c;
        acc = 0;
        v   = '0;
        if (line_mem[4] != CHAR_SPACE || line_mem[5] != CHAR_P || line_mem[6] != CHAR_P ||
            line_mem[7] != CHAR_M || line_mem[8] != CHAR_CR)
            return 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            c = line_mem[k];
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                acc = acc * 10 + int'(c - CHAR_ZERO);
            else if (k == 3 || c != CHAR_SPACE || acc != 0)
                return 1'b0;
            else
                acc = acc * 10;
        end
        v = VALUE_W'(acc);
        return 1'b1;
    endfunction

    function automatic bit predict_line(input logic [7:0] b, output result_t r);
        logic [VALUE_W-1:0] v;
        r = '0;
        if (line_pos >= BUF_LEN - 1)
        begin
            line_pos = 0;
            return 1'b0;
        end
        if (line_pos < LINE_KEEP)
            line_mem[line_pos] = b;
        line_pos++;
        if (b != CHAR_LF)
            return 1'b0;
        if (line_pos != LINE_TOTAL)
        begin
            line_pos = 0;
            return 1'b0;
        end
        line_pos = 0;
        if (decode_value(v))
            r.ppm_value = v;
        else
            r.parse_error = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int      n;
        result_t r;
        n = gap_len(no_idle);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_line(b, r))
            expected_ppm_q.push_back(use_typed ? typed_res : r);
        bytes_sent++;
    endtask

    initial
    begin
        int         s;
        out_stall = 1'b0;
        forever
        begin
            repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30)) @(posedge clk);
            s = gap_len(1'b0);
            if (s > 0)
            begin
                out_stall <= 1'b1;
                repeat (s) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ppm_q.size() == 0)
            begin
                $error("Result with none expected: ppm_value %0d, parse_error %0b",
                       ppm_value, parse_error);
                err_count++;
            end
            else
            begin
                e = expected_ppm_q.pop_front();
                if (ppm_value !== e.ppm_value)
                begin
                    $error("ppm_value mismatch: expected %0d, actual %0d",
                           e.ppm_value, ppm_value);
                    err_count++;
                end
                if (parse_error !== e.parse_error)
                begin
                    $error("parse_error mismatch: expected %0b, actual %0b",
                           e.parse_error, parse_error);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int         n;
        int         kind;
        string      s;
        logic [7:0] line_buf [$];
        line_pos   = 0;
        use_typed  = 1'b0;
        no_idle    = 1'b0;
        bytes_sent = 0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        rst_n      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            s                     = dir_text[i];
            use_typed             = dir_typed[i];
            typed_res.ppm_value   = dir_ppm[i];
            typed_res.parse_error = dir_err[i];
            for (int j = 0; j < s.len(); j++)
                send_byte(s[j]);
        end
        use_typed = 1'b0;

        while (bytes_sent < TARGET_BYTES)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            line_buf.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                for (int j = 0; j < 4; j++)
                    line_buf.push_back(value_char());
                line_buf.push_back(CHAR_SPACE);
                line_buf.push_back(CHAR_P);
                line_buf.push_back(CHAR_P);
                line_buf.push_back(CHAR_M);
                line_buf.push_back(CHAR_CR);
                line_buf.push_back(CHAR_LF);
                if ($urandom_range(0, 6) == 0)
                    line_buf[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
            end
            else if (kind < 80)
            begin
                n = $urandom_range(1, 25);
                for (int j = 0; j < n; j++)
                    line_buf.push_back(($urandom_range(0, 7) == 0) ? CHAR_LF :
                                       8'($urandom_range(0, 255)));
            end
            else if (kind < 90)
            begin
                for (int j = 0; j < BUF_LEN - 1; j++)
                    line_buf.push_back(rand_non_lf());
                line_buf.push_back(($urandom_range(0, 1) == 0) ? CHAR_LF : rand_non_lf());
            end
            else
            begin
                n = $urandom_range(0, 14);
                for (int j = 0; j < n; j++)
                    line_buf.push_back(rand_non_lf());
                line_buf.push_back(CHAR_LF);
            end
            foreach (line_buf[j])
                send_byte(line_buf[j]);
        end
        in_valid <= 1'b0;

        while (expected_ppm_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
